// ===== rtl/fcdo_pkg.sv =====
package fcdo_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;

  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int PIX_W   = 16;
  localparam int NDIGITS = 4;
  localparam int BCD_W   = 4 * NDIGITS;

  localparam logic [X_W-1:0] BOX_X0 = X_W'(2);
  localparam logic [X_W-1:0] BOX_X1 = X_W'(51);
  localparam logic [Y_W-1:0] BOX_Y0 = Y_W'(2);
  localparam logic [Y_W-1:0] BOX_Y1 = Y_W'(20);
  localparam logic [X_W-1:0] ORG_X  = X_W'(4);
  localparam logic [Y_W-1:0] ORG_Y  = Y_W'(4);

  localparam logic [PIX_W-1:0] COLOR_WHITE = 16'hFFFF;
  localparam logic [PIX_W-1:0] COLOR_BLACK = 16'h0000;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [3:0]       digit_t;

  typedef struct packed {
    logic in_box;
    logic lit;
  } paint_t;

  localparam logic [2:0] GLYPHS [10][5] = '{
    '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
    '{3'h2, 3'h6, 3'h2, 3'h2, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
    '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
    '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
    '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
    '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7}
  };

  function automatic digit_t clean_digit(input digit_t d);
    clean_digit = (d > 4'd9) ? 4'd0 : d;
  endfunction

  function automatic logic [2:0] div3(input logic [4:0] v);
    div3 = 3'(v >= 5'd3) + 3'(v >= 5'd6) + 3'(v >= 5'd9) +
           3'(v >= 5'd12) + 3'(v >= 5'd15);
  endfunction

endpackage

// ===== rtl/fcdo_if.sv =====
interface fcdo_pixel_in_if;
  logic                        valid;
  logic                        ready;
  logic [fcdo_pkg::X_W-1:0]    pixel_x;
  logic [fcdo_pkg::Y_W-1:0]    pixel_y;
  logic [fcdo_pkg::PIX_W-1:0]  pixel_in;
  logic                        frame_end;

  modport source (output valid, pixel_x, pixel_y, pixel_in, frame_end, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_in, frame_end, output ready);
endinterface

interface fcdo_pixel_out_if;
  logic                        valid;
  logic                        ready;
  logic [fcdo_pkg::PIX_W-1:0]  pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

// ===== rtl/fcdo_counter.sv =====
module fcdo_counter (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  output fcdo_pkg::bcd_t digits
);
  import fcdo_pkg::*;

  bcd_t digits_next;

  always_comb begin
    logic   carry;
    digit_t d;
    carry = 1'b1;
    digits_next = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      d = clean_digit(digits[i*4 +: 4]);
      if (carry && d == 4'd9) begin
        d = 4'd0;
      end else begin
        d = d + 4'(carry);
        carry = 1'b0;
      end
      digits_next[i*4 +: 4] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
    end else if (step) begin
      digits <= digits_next;
    end
  end

endmodule

// ===== rtl/fcdo_paint.sv =====
module fcdo_paint (
  input  logic [fcdo_pkg::X_W-1:0] pixel_x,
  input  logic [fcdo_pkg::Y_W-1:0] pixel_y,
  input  fcdo_pkg::bcd_t           digits,
  output fcdo_pkg::paint_t         paint
);
  import fcdo_pkg::*;

  logic       in_glyph_area;
  logic [5:0] dx;
  logic [4:0] dy;
  logic [1:0] slot;
  logic [3:0] rem;
  logic [2:0] col;
  logic [2:0] row;
  digit_t     d;
  logic [2:0] bits;

  always_comb begin
    paint.in_box = (int'(pixel_x) < SCREEN_WIDTH) && (int'(pixel_y) < SCREEN_HEIGHT) &&
                   pixel_x >= BOX_X0 && pixel_x <= BOX_X1 &&
                   pixel_y >= BOX_Y0 && pixel_y <= BOX_Y1;
    in_glyph_area = pixel_x >= ORG_X && pixel_y >= ORG_Y;

    dx   = 6'(pixel_x - ORG_X);
    dy   = 5'(pixel_y - ORG_Y);
    slot = 2'(dx >= 6'd12) + 2'(dx >= 6'd24) + 2'(dx >= 6'd36);
    rem  = 4'(dx - 6'(slot) * 6'd12);
    col  = div3({1'b0, rem});
    row  = div3(dy);

    d    = clean_digit(digits[(2'(NDIGITS - 1) - slot)*4 +: 4]);
    bits = (row < 3'd5) ? GLYPHS[d][row] : 3'd0;

    paint.lit = in_glyph_area && row < 3'd5 && col < 3'd3 && bits[2'(3'd2 - col)];
  end

endmodule

// ===== rtl/frame_counter_digit_overlay_unit.sv =====
// Frame counter overlay for an RGB565 pixel stream.
//
// upstream carries one pixel per transfer: pixel_x, pixel_y, pixel_in and
// frame_end. downstream carries the painted pixel_out, one per input pixel,
// in order. While overlay_enable is set, a black box over x 2..51, y 2..20
// holds a white four-digit decimal frame count; other pixels pass through.
// The count advances after a frame_end pixel while enabled; it wraps at 9999.
//
// An upstream transfer reaches pixel_out through one input register, then
// the result register fed by the paint logic and the counter. Throughput is
// one pixel per cycle while downstream is ready; the paint path is a single
// registered pass with no iteration.
//
// Reset clears the count to 0000, sets overlay_enable and empties both
// registers. When downstream stalls, the result register holds and the
// input register still takes one more pixel; upstream ready drops only when
// both are full. Write cfg_wdata with cfg_we only while the stream is idle.
module frame_counter_digit_overlay_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  fcdo_pixel_in_if.sink     upstream,
  fcdo_pixel_out_if.source  downstream
);
  import fcdo_pkg::*;

  logic             overlay_enable;
  logic             stage_valid;
  logic [X_W-1:0]   stage_x;
  logic [Y_W-1:0]   stage_y;
  logic [PIX_W-1:0] stage_pix;
  logic             stage_fend;
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic [PIX_W-1:0] out_pix_next;
  logic             advance;
  logic             step;
  bcd_t             digits;
  paint_t           paint;

  assign advance        = stage_valid && (!out_valid || downstream.ready);
  assign upstream.ready = !stage_valid || advance;
  assign step           = advance && overlay_enable && stage_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_enable <= 1'b1;
    end else if (cfg_we) begin
      overlay_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (upstream.ready) begin
      stage_valid <= upstream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upstream.valid && upstream.ready) begin
      stage_x    <= upstream.pixel_x;
      stage_y    <= upstream.pixel_y;
      stage_pix  <= upstream.pixel_in;
      stage_fend <= upstream.frame_end;
    end
  end

  fcdo_counter u_counter (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .digits (digits)
  );

  fcdo_paint u_paint (
    .pixel_x (stage_x),
    .pixel_y (stage_y),
    .digits  (digits),
    .paint   (paint)
  );

  always_comb begin
    if (overlay_enable && paint.in_box) begin
      out_pix_next = paint.lit ? COLOR_WHITE : COLOR_BLACK;
    end else begin
      out_pix_next = stage_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (downstream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix <= out_pix_next;
    end
  end

  assign downstream.valid     = out_valid;
  assign downstream.pixel_out = out_pix;

endmodule

// ===== tb/sv/frame_counter_digit_overlay_unit_tb.sv =====
module frame_counter_digit_overlay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcdo_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int SWEEP_FRAMES   = 120;
  localparam int MAX_REPORTS    = 40;
  localparam int CELL_PX        = 3;
  localparam int DIGIT_PITCH    = 12;
  localparam int GLYPH_ROWS     = 5;
  localparam int GLYPH_COLS     = 3;
  localparam int TIMEOUT_NS     = 2_000_000;

  typedef enum logic [1:0] {
    PAINT_PASS,
    PAINT_BOX,
    PAINT_DIGIT
  } paint_kind_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] color;
    logic             frame_end;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  logic             in_valid = 1'b0;
  logic [X_W-1:0]   in_x = '0;
  logic [Y_W-1:0]   in_y = '0;
  logic [PIX_W-1:0] in_color = '0;
  logic             in_frame_end = 1'b0;
  logic             out_ready = 1'b0;
  logic             in_xfer = 1'b0;

  pixel_item_t      pending_pixels[$];
  logic [PIX_W-1:0] expected_colors[$];

  int unsigned queued_pixels = 0;
  int unsigned accepted_pixels = 0;
  int unsigned checked_pixels = 0;
  int unsigned mismatch_count = 0;
  int unsigned box_pixels = 0;
  int unsigned digit_pixels = 0;
  int unsigned offscreen_pixels = 0;
  int unsigned bypass_pixels = 0;
  int unsigned stepped_frames = 0;
  int unsigned counter_wraps = 0;

  int idle_pct = 24;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  logic overlay_on = 1'b1;
  bcd_t frame_bcd = '0;

  fcdo_pixel_in_if  pix_in_bus ();
  fcdo_pixel_out_if pix_out_bus ();

  assign pix_in_bus.valid     = in_valid;
  assign pix_in_bus.pixel_x   = in_x;
  assign pix_in_bus.pixel_y   = in_y;
  assign pix_in_bus.pixel_in  = in_color;
  assign pix_in_bus.frame_end = in_frame_end;
  assign pix_out_bus.ready    = out_ready;

  frame_counter_digit_overlay_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .upstream   (pix_in_bus),
    .downstream (pix_out_bus)
  );

  always #2 clk = ~clk;

  function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [3:0] d, input int unsigned row);
    logic [GLYPH_ROWS*GLYPH_COLS-1:0] g;
    case (d)
      4'd1: g = 15'b010_110_010_010_111;
      4'd2: g = 15'b111_001_111_100_111;
      4'd3: g = 15'b111_001_111_001_111;
      4'd4: g = 15'b101_101_111_001_001;
      4'd5: g = 15'b111_100_111_001_111;
      4'd6: g = 15'b111_100_111_101_111;
      4'd7: g = 15'b111_001_001_001_001;
      4'd8: g = 15'b111_101_111_101_111;
      4'd9: g = 15'b111_101_111_001_111;
      default: g = 15'b111_101_101_101_111;
    endcase
    return g[GLYPH_ROWS*GLYPH_COLS-1 - GLYPH_COLS*row -: GLYPH_COLS];
  endfunction

  function automatic paint_kind_t classify_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    int unsigned dx, dy, slot, col, row;
    logic [3:0] d;
    logic [GLYPH_COLS-1:0] bits;
    if (!overlay_on || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT ||
        x < BOX_X0 || x > BOX_X1 || y < BOX_Y0 || y > BOX_Y1)
      return PAINT_PASS;
    if (x < ORG_X || y < ORG_Y)
      return PAINT_BOX;
    dx = x - ORG_X;
    dy = y - ORG_Y;
    row = dy / CELL_PX;
    slot = dx / DIGIT_PITCH;
    col = (dx % DIGIT_PITCH) / CELL_PX;
    if (row >= GLYPH_ROWS || slot >= NDIGITS || col >= GLYPH_COLS)
      return PAINT_BOX;
    d = frame_bcd[(NDIGITS - 1 - slot) * 4 +: 4];
    if (d > 4'd9)
      d = 4'd0;
    bits = glyph_row(d, row);
    return bits[GLYPH_COLS - 1 - col] ? PAINT_DIGIT : PAINT_BOX;
  endfunction

  function automatic bcd_t next_frame_count(input bcd_t cur);
    bcd_t nxt;
    logic [3:0] d;
    logic carry;
    carry = 1'b1;
    nxt = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      d = cur[i*4 +: 4];
      if (d > 4'd9)
        d = 4'd0;
      d = d + 4'(carry);
      if (d > 4'd9) begin
        d = 4'd0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      nxt[i*4 +: 4] = d;
    end
    return nxt;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // model the overlay and check the output stream
  always @(posedge clk) begin
    paint_kind_t kind;
    logic [PIX_W-1:0] want;
    if (rst) begin
      overlay_on = 1'b1;
      frame_bcd = '0;
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= pix_in_bus.valid && pix_in_bus.ready;
      if (cfg_we)
        overlay_on = cfg_wdata;
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        kind = classify_pixel(pix_in_bus.pixel_x, pix_in_bus.pixel_y);
        case (kind)
          PAINT_BOX: begin
            want = COLOR_BLACK;
            box_pixels++;
          end
          PAINT_DIGIT: begin
            want = COLOR_WHITE;
            digit_pixels++;
          end
          default: want = pix_in_bus.pixel_in;
        endcase
        if (pix_in_bus.pixel_x >= SCREEN_WIDTH || pix_in_bus.pixel_y >= SCREEN_HEIGHT)
          offscreen_pixels++;
        if (!overlay_on)
          bypass_pixels++;
        expected_colors.push_back(want);
        accepted_pixels++;
        if (overlay_on && pix_in_bus.frame_end) begin
          if (frame_bcd == 16'h9999)
            counter_wraps++;
          frame_bcd = next_frame_count(frame_bcd);
          stepped_frames++;
        end
      end
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("pixel_out %h with no pixel pending",
                                    pix_out_bus.pixel_out));
        end else begin
          want = expected_colors.pop_front();
          if (pix_out_bus.pixel_out !== want)
            report_mismatch($sformatf("pixel %0d: pixel_out %h, want %h",
                                      checked_pixels, pix_out_bus.pixel_out, want));
        end
        checked_pixels++;
      end
    end
  end

  // advance to the next pending pixel once the current one transfers
  always @(negedge clk) begin
    pixel_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        item = pending_pixels.pop_front();
        in_x <= item.x;
        in_y <= item.y;
        in_color <= item.color;
        in_frame_end <= item.frame_end;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // drop ready at random, or for a long hold when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic queue_pixel(input int x, input int y, input int color, input bit fe);
    pixel_item_t item;
    item.x = X_W'(x);
    item.y = Y_W'(y);
    item.color = PIX_W'(color);
    item.frame_end = fe;
    pending_pixels.push_back(item);
    queued_pixels++;
  endtask

  task automatic queue_random_pixel(input int frame_end_pct);
    int sel, x, y;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      x = $urandom_range(0, 55);
      y = $urandom_range(0, 23);
    end else if (sel < 85) begin
      x = $urandom_range(0, SCREEN_WIDTH - 1);
      y = $urandom_range(0, SCREEN_HEIGHT - 1);
    end else begin
      x = $urandom_range(0, (1 << X_W) - 1);
      y = $urandom_range(0, (1 << Y_W) - 1);
    end
    queue_pixel(x, y, $urandom, $urandom_range(0, 99) < frame_end_pct);
  endtask

  task automatic wait_for_drain();
    do
      @(negedge clk);
    while (accepted_pixels != queued_pixels || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_overlay_enable(input logic on);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input int frame_end_pct);
    repeat (count) queue_random_pixel(frame_end_pct);
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_overlay_enable(1'b1);
    queue_pixel(0, 0, 16'h0000, 0);
    queue_pixel(1, 2, 16'hFFFF, 0);
    queue_pixel(2, 1, 16'h1234, 0);
    queue_pixel(2, 2, 16'hFFFF, 0);
    queue_pixel(51, 20, 16'hABCD, 0);
    queue_pixel(52, 20, 16'h5555, 0);
    queue_pixel(51, 21, 16'hAAAA, 0);
    queue_pixel(4, 4, 16'h0000, 0);
    queue_pixel(7, 7, 16'h0000, 0);
    queue_pixel(15, 4, 16'hFFFF, 0);
    queue_pixel(42, 18, 16'h1111, 0);
    queue_pixel(799, 479, 16'h8001, 0);
    queue_pixel(800, 10, 16'h7FFF, 0);
    queue_pixel(10, 480, 16'hF0F0, 1);
    queue_pixel(44, 5, 16'h0F0F, 1);
    queue_pixel(1023, 511, 16'hFFFF, 0);
    queue_pixel(51, 2, 16'h0000, 1);
    queue_pixel(47, 18, 16'hC3C3, 0);
    wait_for_drain();

    write_overlay_enable(1'b0);
    queue_pixel(4, 4, 16'h1234, 1);
    queue_pixel(30, 10, 16'hBEEF, 0);
    wait_for_drain();

    write_overlay_enable(1'b1);
    queue_pixel(44, 4, 16'h0000, 0);
    wait_for_drain();

    // stall the output while the input keeps offering pixels
    hold_requests = hold_requests + 1;
    run_random(40, 15);

    // step the counter on every pixel to roll several digits
    run_random(SWEEP_FRAMES, 100);

    run_random(100, 15);
    write_overlay_enable(1'b0);
    run_random(80, 15);
    write_overlay_enable(1'b1);
    idle_pct = 0;
    run_random(100, 15);
    idle_pct = 24;
    run_random(80, 15);

    $display("Checked %0d pixels: %0d box, %0d digit cells, %0d off screen, %0d bypassed",
             checked_pixels, box_pixels, digit_pixels, offscreen_pixels, bypass_pixels);
    $display("Frame counter stepped %0d times, wrapped %0d times, ended at %h",
             stepped_frames, counter_wraps, frame_bcd);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d pixels outstanding", expected_colors.size());
    $display("Verification failed");
    $finish;
  end

endmodule
